// ===== rtl/q5_block_unpacker_macros.svh =====
// ----------------------------------------------------------------------------
// q5 block unpacker assertion macros
// Shared concurrent assertion helpers.
// ----------------------------------------------------------------------------
`ifndef Q5_BLOCK_UNPACKER_MACROS_SVH
`define Q5_BLOCK_UNPACKER_MACROS_SVH
`ifndef SYNTHESIS
`define Q5_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define Q5_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define Q5_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define Q5_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/q5bu_pkg.sv =====
// ----------------------------------------------------------------------------
// q5bu_pkg
// Types, constants and scale conversion for the q5 block unpacker.
// ----------------------------------------------------------------------------
package q5bu_pkg;
    localparam int unsigned WORDS      = 5;
    localparam int unsigned IDX_W      = 3;
    localparam int unsigned QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [31:0] scale;
        logic [31:0] high_bits;
        logic [63:0] nib_lo;
        logic [63:0] nib_hi;
        logic        fin;
    } t_entry;

    function automatic logic [31:0] half_to_single(input logic [15:0] h);
        logic [4:0]  ex;
        logic [9:0]  man;
        logic [3:0]  lz;
        logic [10:0] sh;
        logic [7:0]  e32;
        logic [31:0] res;
        ex  = h[14:10];
        man = h[9:0];
        lz  = 4'd0;
        for (int i = 9; i >= 0; i--) begin
            if (man[i] && lz == 4'd0 && (man >> i) == 10'd1) lz = 4'(10 - i);
        end
        sh  = {1'b0, man} << lz;
        e32 = 8'(8'd113 - {4'd0, lz});
        if (ex == 5'd0) begin
            if (man == 10'd0) res = {h[15], 31'd0};
            else              res = {h[15], e32, sh[9:0], 13'd0};
        end else if (ex == 5'h1F) begin
            res = {h[15], 8'hFF, man, 13'd0};
        end else begin
            res = {h[15], 8'({3'd0, ex} + 8'd112), man, 13'd0};
        end
        return res;
    endfunction
endpackage

// ===== rtl/q5bu_front.sv =====
// ----------------------------------------------------------------------------
// q5bu_front
// Accept blocks, convert the scale and push them into a two-entry queue.
// ----------------------------------------------------------------------------
module q5bu_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [15:0]       i_half_scale,
    input  logic [31:0]       i_high_bits,
    input  logic [63:0]       i_nibbles_first,
    input  logic [63:0]       i_nibbles_second,
    input  logic              i_final_block,
    output logic              o_q_valid,
    output q5bu_pkg::t_entry  o_q_data,
    input  logic              i_q_pop
);
    import q5bu_pkg::*;

    t_entry     r_mem [QUEUE_DEPTH];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       push;

    assign o_ready   = r_cnt != 2'(QUEUE_DEPTH);
    assign push      = i_valid && o_ready;
    assign o_q_valid = r_cnt != 2'd0;
    assign o_q_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= '{half_to_single(i_half_scale), i_high_bits,
                             i_nibbles_first, i_nibbles_second, i_final_block};
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (i_q_pop) r_rp <= ~r_rp;
            r_cnt <= 2'(r_cnt + {1'b0, push} - {1'b0, i_q_pop});
        end
    end
endmodule

// ===== rtl/q5bu_back.sv =====
// ----------------------------------------------------------------------------
// q5bu_back
// Serialize one queued block into five output words.
// ----------------------------------------------------------------------------
`include "q5_block_unpacker_macros.svh"
module q5bu_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  q5bu_pkg::t_entry  i_q_data,
    output logic              o_q_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [2:0]        o_word_index,
    output logic [63:0]       o_word_data,
    output logic              o_block_last,
    output logic              o_tensor_end
);
    import q5bu_pkg::*;

    logic [IDX_W-1:0] r_idx;
    logic [IDX_W-1:0] r_index;
    logic             r_valid;
    logic [63:0]      r_data;
    logic             r_last, r_end;
    logic             load;
    logic [63:0]      n_data;
    logic [319:0]     bytes;

    always_comb begin
        bytes = '0;
        bytes[31:0] = i_q_data.scale;
        for (int j = 0; j < 8; j++) begin
            bytes[32 + 8*j +: 8]  = {3'd0, i_q_data.high_bits[j],
                                     i_q_data.nib_lo[8*j +: 4]};
            bytes[96 + 8*j +: 8]  = {3'd0, i_q_data.high_bits[8+j],
                                     i_q_data.nib_hi[8*j +: 4]};
            bytes[160 + 8*j +: 8] = {3'd0, i_q_data.high_bits[16+j],
                                     i_q_data.nib_lo[8*j+4 +: 4]};
            bytes[224 + 8*j +: 8] = {3'd0, i_q_data.high_bits[24+j],
                                     i_q_data.nib_hi[8*j+4 +: 4]};
        end
        n_data = '0;
        case (r_idx)
            3'd0:    n_data = bytes[63:0];
            3'd1:    n_data = bytes[127:64];
            3'd2:    n_data = bytes[191:128];
            3'd3:    n_data = bytes[255:192];
            default: n_data = bytes[319:256];
        endcase
    end

    assign load    = i_q_valid && (!r_valid || i_ready);
    assign o_q_pop = load && r_idx == 3'(WORDS - 1);

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_data  <= n_data;
            r_last  <= r_idx == 3'(WORDS - 1);
            r_end   <= r_idx == 3'(WORDS - 1) && i_q_data.fin;
            r_index <= r_idx;
        end
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (load) r_idx <= (r_idx == 3'(WORDS - 1)) ? '0 : 3'(r_idx + 3'd1);
            if (load) r_valid <= 1'b1;
            else if (i_ready) r_valid <= 1'b0;
        end
    end

    assign o_valid      = r_valid;
    assign o_word_index = r_index;
    assign o_word_data  = r_data;
    assign o_block_last = r_last;
    assign o_tensor_end = r_end;

    `Q5_ASSERT_IMPL(a_idx_range, i_clk, i_rst_n, 1'b1, r_idx <= 3'(WORDS - 1))
    `Q5_ASSERT_IMPL(a_end_last, i_clk, i_rst_n, o_valid && o_tensor_end, o_block_last)
    `Q5_ASSERT_NEXT(a_pop_wrap, i_clk, i_rst_n, o_q_pop, r_idx == 3'd0)
endmodule

// ===== rtl/q5_block_unpacker.sv =====
// An accepted block is registered in the queue, and each word then in the output register.
// Block rate is set by the five-word output serializer and by stalls on i_ready.
// A two-block queue lets the input side accept while words still drain.
// Reset: synchronous active low; clears the queue and serializer control.
// ----------------------------------------------------------------------------
// q5_block_unpacker
// Unpack a 5-bit quantized block into five 64-bit words.
// ----------------------------------------------------------------------------
module q5_block_unpacker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [15:0] i_half_scale,
    input  logic [31:0] i_high_bits,
    input  logic [63:0] i_nibbles_first,
    input  logic [63:0] i_nibbles_second,
    input  logic        i_final_block,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_word_index,
    output logic [63:0] o_word_data,
    output logic        o_block_last,
    output logic        o_tensor_end
);
    import q5bu_pkg::*;

    logic   q_valid, q_pop;
    t_entry q_data;

    q5bu_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_half_scale, .i_high_bits,
        .i_nibbles_first, .i_nibbles_second, .i_final_block,
        .o_q_valid(q_valid), .o_q_data(q_data), .i_q_pop(q_pop)
    );

    q5bu_back u_back (
        .i_clk, .i_rst_n, .i_q_valid(q_valid), .i_q_data(q_data), .o_q_pop(q_pop),
        .o_valid, .i_ready, .o_word_index, .o_word_data, .o_block_last,
        .o_tensor_end
    );
endmodule
